/* design/srvm_pkg.sv */
// Shared types and constants of the stack/register VM execute unit.
`timescale 1ns / 1ps
`default_nettype none

package srvm_pkg;

    localparam int WORD_W          = 64;
    localparam int FUNC_W          = 5;
    localparam int RIDX_W          = 2;
    localparam int FAULT_W         = 2;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_REGS_DEF    = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_MOVRL    = 5'd0,
        FN_MOVRR    = 5'd1,
        FN_MOVRM    = 5'd2,
        FN_MOVML    = 5'd3,
        FN_MOVMR    = 5'd4,
        FN_MOVMM    = 5'd5,
        FN_PUSHL    = 5'd6,
        FN_PUSHR    = 5'd7,
        FN_PUSHM    = 5'd8,
        FN_POP      = 5'd9,
        FN_POPR     = 5'd10,
        FN_POPM     = 5'd11,
        FN_SWAP     = 5'd12,
        FN_ROTL     = 5'd13,
        FN_ROTR     = 5'd14,
        FN_DUP      = 5'd15,
        FN_ADD      = 5'd16,
        FN_PUSHBASE = 5'd17,
        FN_EXIT     = 5'd18
    } func_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_UNDERFLOW = 2'd1,
        FAULT_OVERFLOW  = 2'd2
    } fault_t;

    typedef enum logic [2:0] {
        SOP_NONE = 3'd0,
        SOP_PUSH = 3'd1,
        SOP_POP  = 3'd2,
        SOP_SWAP = 3'd3,
        SOP_ROTL = 3'd4,
        SOP_ROTR = 3'd5,
        SOP_ADD  = 3'd6
    } stack_op_t;

    typedef struct packed {
        stack_op_t         op;
        logic [WORD_W-1:0] data;
    } stack_cmd_t;

endpackage

`default_nettype wire

/* design/srvm_stack.sv */
// Shift-register stack with the top entry at index 0.
`timescale 1ns / 1ps
`default_nettype none

module srvm_stack #(
    parameter int STACK_DEPTH = srvm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire srvm_pkg::stack_cmd_t       cmd,
    output logic [srvm_pkg::WORD_W-1:0]     top0
);
    import srvm_pkg::*;

    logic [WORD_W-1:0] stack_reg  [STACK_DEPTH];
    logic [WORD_W-1:0] stack_next [STACK_DEPTH];

    always_comb
    begin
        stack_next = stack_reg;
        unique case (cmd.op)
            SOP_PUSH:
            begin
                stack_next[0] = cmd.data;
                for (int i = 1; i < STACK_DEPTH; i++)
                begin
                    stack_next[i] = stack_reg[i-1];
                end
            end
            SOP_POP:
            begin
                for (int i = 0; i < STACK_DEPTH - 1; i++)
                begin
                    stack_next[i] = stack_reg[i+1];
                end
            end
            SOP_ADD:
            begin
                stack_next[0] = stack_reg[0] + stack_reg[1];
                for (int i = 1; i < STACK_DEPTH - 1; i++)
                begin
                    stack_next[i] = stack_reg[i+1];
                end
            end
            SOP_SWAP:
            begin
                stack_next[0] = stack_reg[1];
                stack_next[1] = stack_reg[0];
            end
            SOP_ROTL:
            begin
                stack_next[0] = stack_reg[2];
                stack_next[1] = stack_reg[0];
                stack_next[2] = stack_reg[1];
            end
            SOP_ROTR:
            begin
                stack_next[0] = stack_reg[1];
                stack_next[1] = stack_reg[2];
                stack_next[2] = stack_reg[0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
    end

    assign top0 = stack_reg[0];

endmodule

`default_nettype wire

/* design/stack_register_vm_execute.sv */
// Top level of the stack/register VM execute unit.
`timescale 1ns / 1ps
`default_nettype none

// Executes one decoded instruction per clock cycle. An instruction is taken when start is
// high (busy is always low), held in an input register, executed in the next cycle, and
// its result is registered and appears on the result ports with done high for one cycle;
// results cannot be held off, so capture them when done is high. The stack is a shift
// register with the top entry first, so stack contents need no clearing after reset;
// registers, depth and the halt bit reset to zero. Write code_base through
// cfg_write/cfg_wdata only while no instruction is in flight.
module stack_register_vm_execute #(
    parameter int  STACK_DEPTH = srvm_pkg::STACK_DEPTH_DEF,
    parameter int  NUM_REGS    = srvm_pkg::NUM_REGS_DEF,
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [srvm_pkg::WORD_W-1:0]   cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [srvm_pkg::FUNC_W-1:0]   func,
    input  wire logic [srvm_pkg::RIDX_W-1:0]   dest_reg,
    input  wire logic [srvm_pkg::RIDX_W-1:0]   src_reg,
    input  wire logic [srvm_pkg::WORD_W-1:0]   literal,
    input  wire logic [srvm_pkg::WORD_W-1:0]   write_addr,
    input  wire logic [srvm_pkg::WORD_W-1:0]   read_data,
    output logic                               done,
    output logic                               mem_write,
    output logic [srvm_pkg::WORD_W-1:0]        mem_addr,
    output logic [srvm_pkg::WORD_W-1:0]        mem_data,
    output logic [srvm_pkg::FAULT_W-1:0]       fault,
    output logic                               halted,
    output logic [CNT_W-1:0]                   depth
);
    import srvm_pkg::*;

    localparam int RI_W = $clog2(NUM_REGS);

    // input register
    logic                 valid_reg;
    logic [FUNC_W-1:0]    in_func_reg;
    logic [RIDX_W-1:0]    in_dest_reg;
    logic [RIDX_W-1:0]    in_src_reg;
    logic [WORD_W-1:0]    in_lit_reg;
    logic [WORD_W-1:0]    in_waddr_reg;
    logic [WORD_W-1:0]    in_rdata_reg;

    // architectural state
    logic [WORD_W-1:0]    code_base_reg;
    logic [WORD_W-1:0]    rf_reg [NUM_REGS];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 halt_reg;
    logic                 halt_next;

    // result register
    logic                 done_reg;
    logic                 mem_write_reg;
    logic                 mem_write_next;
    logic [WORD_W-1:0]    mem_addr_reg;
    logic [WORD_W-1:0]    mem_addr_next;
    logic [WORD_W-1:0]    mem_data_reg;
    logic [WORD_W-1:0]    mem_data_next;
    fault_t               fault_reg;
    fault_t               fault_next;

    logic [1:0]           need;
    logic                 grow;
    logic                 exec;
    logic [31:0]          src_wide;
    logic [31:0]          dest_wide;
    logic [WORD_W-1:0]    src_val;
    logic                 rf_we;
    logic [WORD_W-1:0]    rf_wval;
    logic [WORD_W-1:0]    top0;
    stack_cmd_t           scmd;
    func_t                fn;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_func_reg  <= func;
            in_dest_reg  <= dest_reg;
            in_src_reg   <= src_reg;
            in_lit_reg   <= literal;
            in_waddr_reg <= write_addr;
            in_rdata_reg <= read_data;
        end
    end

    assign fn        = func_t'(in_func_reg);
    assign src_wide  = 32'(in_src_reg);
    assign dest_wide = 32'(in_dest_reg);
    assign src_val   = (src_wide < NUM_REGS) ? rf_reg[src_wide[RI_W-1:0]] : '0;

    always_comb
    begin
        need = 2'd0;
        grow = 1'b0;
        unique case (fn)
            FN_PUSHL, FN_PUSHR, FN_PUSHM, FN_PUSHBASE: grow = 1'b1;
            FN_POP, FN_POPR, FN_POPM:                  need = 2'd1;
            FN_SWAP, FN_ADD:                           need = 2'd2;
            FN_ROTL, FN_ROTR:                          need = 2'd3;
            FN_DUP:
            begin
                need = 2'd1;
                grow = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        fault_next = FAULT_NONE;
        if (!halt_reg)
        begin
            priority if (count_reg < CNT_W'(need))
            begin
                fault_next = FAULT_UNDERFLOW;
            end
            else if (grow && (count_reg == CNT_W'(STACK_DEPTH)))
            begin
                fault_next = FAULT_OVERFLOW;
            end
            else
            begin
                fault_next = FAULT_NONE;
            end
        end
    end

    assign exec = valid_reg && !halt_reg && (fault_next == FAULT_NONE);

    always_comb
    begin
        rf_we          = 1'b0;
        rf_wval        = in_lit_reg;
        mem_write_next = 1'b0;
        mem_addr_next  = '0;
        mem_data_next  = '0;
        scmd.op        = SOP_NONE;
        scmd.data      = in_lit_reg;
        count_next     = count_reg;
        halt_next      = halt_reg;
        if (exec)
        begin
            unique case (fn)
                FN_MOVRL:
                begin
                    rf_we   = 1'b1;
                    rf_wval = in_lit_reg;
                end
                FN_MOVRR:
                begin
                    rf_we   = 1'b1;
                    rf_wval = src_val;
                end
                FN_MOVRM:
                begin
                    rf_we   = 1'b1;
                    rf_wval = in_rdata_reg;
                end
                FN_MOVML:
                begin
                    mem_write_next = 1'b1;
                    mem_addr_next  = in_waddr_reg;
                    mem_data_next  = in_lit_reg;
                end
                FN_MOVMR:
                begin
                    mem_write_next = 1'b1;
                    mem_addr_next  = in_waddr_reg;
                    mem_data_next  = src_val;
                end
                FN_MOVMM:
                begin
                    mem_write_next = 1'b1;
                    mem_addr_next  = in_waddr_reg;
                    mem_data_next  = in_rdata_reg;
                end
                FN_PUSHL:
                begin
                    scmd.op    = SOP_PUSH;
                    scmd.data  = in_lit_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                FN_PUSHR:
                begin
                    scmd.op    = SOP_PUSH;
                    scmd.data  = src_val;
                    count_next = count_reg + CNT_W'(1);
                end
                FN_PUSHM:
                begin
                    scmd.op    = SOP_PUSH;
                    scmd.data  = in_rdata_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                FN_POP:
                begin
                    scmd.op    = SOP_POP;
                    count_next = count_reg - CNT_W'(1);
                end
                FN_POPR:
                begin
                    rf_we      = 1'b1;
                    rf_wval    = top0;
                    scmd.op    = SOP_POP;
                    count_next = count_reg - CNT_W'(1);
                end
                FN_POPM:
                begin
                    mem_write_next = 1'b1;
                    mem_addr_next  = in_waddr_reg;
                    mem_data_next  = top0;
                    scmd.op        = SOP_POP;
                    count_next     = count_reg - CNT_W'(1);
                end
                FN_SWAP: scmd.op = SOP_SWAP;
                FN_ROTL: scmd.op = SOP_ROTL;
                FN_ROTR: scmd.op = SOP_ROTR;
                FN_DUP:
                begin
                    scmd.op    = SOP_PUSH;
                    scmd.data  = top0;
                    count_next = count_reg + CNT_W'(1);
                end
                FN_ADD:
                begin
                    scmd.op    = SOP_ADD;
                    count_next = count_reg - CNT_W'(1);
                end
                FN_PUSHBASE:
                begin
                    scmd.op    = SOP_PUSH;
                    scmd.data  = code_base_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                FN_EXIT: halt_next = 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    srvm_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .cmd  (scmd),
        .top0 (top0)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_base_reg <= '0;
            count_reg     <= '0;
            halt_reg      <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                code_base_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            halt_reg  <= halt_next;
            if (rf_we && (dest_wide < NUM_REGS))
            begin
                rf_reg[dest_wide[RI_W-1:0]] <= rf_wval;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            mem_write_reg <= mem_write_next;
            mem_addr_reg  <= mem_addr_next;
            mem_data_reg  <= mem_data_next;
            fault_reg     <= fault_next;
        end
    end

    // halt and depth outputs follow the state written by the last transaction
    assign done      = done_reg;
    assign mem_write = mem_write_reg;
    assign mem_addr  = mem_addr_reg;
    assign mem_data  = mem_data_reg;
    assign fault     = fault_reg;
    assign halted    = halt_reg;
    assign depth     = count_reg;

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("transaction result missing two cycles after start");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg && $stable(count_reg))
        else $error("state changed after halt");

    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        done && (fault_reg != FAULT_NONE) |-> !mem_write && $stable(count_reg))
        else $error("faulted transaction changed state or wrote memory");

endmodule

`default_nettype wire
